[rtl/core/rbrc_pkg.sv]
// Shared types and constants for the ring-buffered rate converter.
package rbrc_pkg;

   // Defaults for the top-level parameters
   localparam int RING_DEPTH_DEF = 16384;
   localparam int FRAME_LEN_DEF  = 2048;
   localparam int OUT_RATE_DEF   = 44100;

   // Fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int STEREO_W   = 2 * SAMPLE_W;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] SOURCE_RATE_RESET   = 16'd44100;
   localparam logic [CSR_DATA_W-1:0] TARGET_VOLUME_RESET = 16'd32768;

   // Result queue
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_FRAME = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_RATE   = 1'b0,
      CSR_TARGET_VOLUME = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type                  action;
      logic signed [SAMPLE_W-1:0]  in_left;
      logic signed [SAMPLE_W-1:0]  in_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  out_left;
      logic signed [SAMPLE_W-1:0]  out_right;
      logic        [GAIN_W-1:0]    gain;
   } rsp_type;

   // Tick command from the front end to the hold stage
   typedef struct packed {
      logic              valid;
      logic              fetch;  // phase crossed, load a new sample
      logic              blank;  // fetched entry never written since reset
      logic [GAIN_W-1:0] gain;
   } tick_type;

endpackage

[rtl/core/rbrc_front.sv]
// Front end: accepts beats, decodes the action, owns counters, phase, gain and registers.
module rbrc_front #(
   parameter int RING_DEPTH = rbrc_pkg::RING_DEPTH_DEF,
   parameter int FRAME_LEN  = rbrc_pkg::FRAME_LEN_DEF,
   parameter int OUT_RATE   = rbrc_pkg::OUT_RATE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  rbrc_pkg::req_type                     req_data,
   input  logic                                  q_full,
   input  logic                                  csr_we,
   input  logic [rbrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rbrc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                  ring_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]         ring_wr_addr,
   output logic [rbrc_pkg::STEREO_W-1:0]         ring_wr_data,
   output logic                                  ring_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]         ring_rd_addr,
   output rbrc_pkg::tick_type                    tick
);
   import rbrc_pkg::*;

   localparam int IW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(2 * RING_DEPTH);
   localparam int PW = $clog2(2 * OUT_RATE);
   localparam int MW = (PW > CSR_DATA_W) ? PW : CSR_DATA_W;
   localparam int GW = GAIN_W + 2;

   localparam logic [CW:0]     COUNT_MOD  = (CW+1)'(2 * RING_DEPTH);
   localparam logic [CW:0]     DEPTH_C    = (CW+1)'(RING_DEPTH);
   localparam logic [CW:0]     FRAME_C    = (CW+1)'(FRAME_LEN);
   localparam logic [CW:0]     FRAME_MOD  = (CW+1)'(FRAME_LEN % (2 * RING_DEPTH));
   localparam logic [CW-1:0]   COUNT_LAST = CW'(2 * RING_DEPTH - 1);
   localparam logic [IW-1:0]   IDX_LAST   = IW'(RING_DEPTH - 1);
   localparam logic [PW-1:0]   OUT_RATE_P = PW'(OUT_RATE);
   localparam logic [MW-1:0]   OUT_RATE_M = MW'(OUT_RATE);

   // Ring position of a count modulo twice the depth
   function automatic logic [IW-1:0] idx_of(input logic [CW-1:0] count);
      logic [CW:0] c;
      c = {1'b0, count};
      if (c >= DEPTH_C) begin
         return IW'(c - DEPTH_C);
      end
      return IW'(c);
   endfunction

   function automatic logic [CW-1:0] count_inc(input logic [CW-1:0] count);
      logic [CW-1:0] n;
      n = (count == COUNT_LAST) ? '0 : count + CW'(1);
      return n;
   endfunction

   logic [CW-1:0]         wr_cnt_ff, wr_cnt_in;
   logic [CW-1:0]         rd_cnt_ff, rd_cnt_in;
   logic                  wrapped_ff, wrapped_in;
   logic [PW-1:0]         phase_ff, phase_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [CSR_DATA_W-1:0] src_rate_ff;
   logic [CSR_DATA_W-1:0] tgt_vol_ff;

   logic              accept;
   logic [CW:0]       w_ext, r_ext, fill, resync;
   logic [IW-1:0]     wr_idx, rd_idx;
   logic              ring_full, need_resync;
   logic [GW-1:0]     ramp, ramped;
   logic [GAIN_W-1:0] gain_clamped;
   logic [MW-1:0]     src_m;
   logic [PW-1:0]     rate, phase_sum;
   logic              fetch;

   // Fill level, resync point, gain ramp and phase step
   always_comb begin
      accept      = req_push && !q_full;
      w_ext       = {1'b0, wr_cnt_ff};
      r_ext       = {1'b0, rd_cnt_ff};
      fill        = (w_ext >= r_ext) ? w_ext - r_ext : w_ext + COUNT_MOD - r_ext;
      resync      = (w_ext >= FRAME_MOD) ? w_ext - FRAME_MOD : w_ext + COUNT_MOD - FRAME_MOD;
      wr_idx      = idx_of(wr_cnt_ff);
      rd_idx      = idx_of(rd_cnt_ff);
      ring_full   = (fill == DEPTH_C);
      need_resync = (fill < FRAME_C) || (fill > DEPTH_C);

      // gain * 3 / 2 + 2, then clamp to target
      ramp   = GW'(gain_ff) + GW'(gain_ff[GAIN_W-1:1]) + GW'(2);
      ramped = (gain_ff < tgt_vol_ff) ? ramp : GW'(gain_ff);
      gain_clamped = (ramped > GW'(tgt_vol_ff)) ? tgt_vol_ff : ramped[GAIN_W-1:0];

      src_m     = MW'(src_rate_ff);
      rate      = (src_m > OUT_RATE_M) ? OUT_RATE_P : PW'(src_m);
      phase_sum = phase_ff + rate;
      fetch     = (phase_sum >= OUT_RATE_P);
   end

   // Next state
   always_comb begin
      wr_cnt_in  = wr_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      wrapped_in = wrapped_ff;
      phase_in   = phase_ff;
      gain_in    = gain_ff;
      if (accept) begin
         case (req_data.action)
            ACT_PUSH: begin
               if (!ring_full) begin
                  wr_cnt_in = count_inc(wr_cnt_ff);
                  if (wr_idx == IDX_LAST) begin
                     wrapped_in = 1'b1;
                  end
               end
            end
            ACT_FRAME: begin
               if (need_resync) begin
                  rd_cnt_in = resync[CW-1:0];
               end
               gain_in = gain_clamped;
            end
            ACT_TICK: begin
               if (fetch) begin
                  rd_cnt_in = count_inc(rd_cnt_ff);
                  phase_in  = phase_sum - OUT_RATE_P;
               end else begin
                  phase_in  = phase_sum;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Ring access and tick command
   always_comb begin
      ring_wr_en   = accept && (req_data.action == ACT_PUSH) && !ring_full;
      ring_wr_addr = wr_idx;
      ring_wr_data = {req_data.in_right, req_data.in_left};
      ring_rd_en   = accept && (req_data.action == ACT_TICK) && fetch;
      ring_rd_addr = rd_idx;
      tick.valid   = accept && (req_data.action == ACT_TICK);
      tick.fetch   = fetch;
      tick.blank   = !wrapped_ff && (rd_idx >= wr_idx);
      tick.gain    = gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff   <= '0;
         rd_cnt_ff   <= '0;
         wrapped_ff  <= 1'b0;
         phase_ff    <= '0;
         gain_ff     <= '0;
         src_rate_ff <= SOURCE_RATE_RESET;
         tgt_vol_ff  <= TARGET_VOLUME_RESET;
      end else begin
         wr_cnt_ff  <= wr_cnt_in;
         rd_cnt_ff  <= rd_cnt_in;
         wrapped_ff <= wrapped_in;
         phase_ff   <= phase_in;
         gain_ff    <= gain_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SOURCE_RATE:   src_rate_ff <= csr_wdata;
               CSR_TARGET_VOLUME: tgt_vol_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

[rtl/core/rbrc_ring.sv]
// Sample ring memory: one write port, one read port with registered read data.
module rbrc_ring #(
   parameter int RING_DEPTH = rbrc_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0]     wr_addr,
   input  logic [rbrc_pkg::STEREO_W-1:0]     wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0]     rd_addr,
   output logic [rbrc_pkg::STEREO_W-1:0]     rd_data
);
   import rbrc_pkg::*;

   logic [STEREO_W-1:0] store_ff [RING_DEPTH];
   logic [STEREO_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/rbrc_back.sv]
// Back end: sample-hold register and result queue feeding the rsp side.
module rbrc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rbrc_pkg::tick_type                tick,
   input  logic [rbrc_pkg::STEREO_W-1:0]     rd_data,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output rbrc_pkg::rsp_type                 rsp_data,
   output logic                              q_full
);
   import rbrc_pkg::*;

   tick_type               s1_ff;
   logic [STEREO_W-1:0]    held_ff, held_in;
   rsp_type                queue_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]     head_ff, tail_ff;
   logic [RSPQ_CW-1:0]     count_ff, count_in;
   logic                   enq, deq;
   rsp_type                enq_beat;
   logic [RSPQ_CW:0]       committed;

   // Hold stage: a fetch loads the ring word, an unwritten entry reads zero
   always_comb begin
      held_in = held_ff;
      if (s1_ff.valid && s1_ff.fetch) begin
         held_in = s1_ff.blank ? '0 : rd_data;
      end
      enq_beat.out_left  = held_in[SAMPLE_W-1:0];
      enq_beat.out_right = held_in[STEREO_W-1:SAMPLE_W];
      enq_beat.gain      = s1_ff.gain;
   end

   // Queue control; space is reserved for the beat in the hold stage
   always_comb begin
      enq       = s1_ff.valid;
      rsp_empty = (count_ff == '0);
      deq       = rsp_pop && !rsp_empty;
      count_in  = count_ff + RSPQ_CW'(enq) - RSPQ_CW'(deq);
      committed = (RSPQ_CW+1)'(count_ff) + (RSPQ_CW+1)'(s1_ff.valid);
      q_full    = (committed >= (RSPQ_CW+1)'(RSPQ_DEPTH));
      rsp_data  = queue_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         held_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         s1_ff    <= tick;
         held_ff  <= held_in;
         count_ff <= count_in;
         if (enq) begin
            tail_ff <= tail_ff + RSPQ_AW'(1);
         end
         if (deq) begin
            head_ff <= head_ff + RSPQ_AW'(1);
         end
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[tail_ff] <= enq_beat;
      end
   end

endmodule

[rtl/core/ring_buffered_rate_converter.sv]
// Top level of the ring-buffered stereo sample-hold rate converter.
// Takes one beat per clock on the req side (push sample, frame start or output
// tick) as long as the four-entry result queue has room; each tick yields one
// result beat, which shows on rsp once the tick has passed the hold-stage register
// and been written into the result queue (the ring read data lands with the hold
// stage). Sustained rate is one beat per clock while rsp drains; each beat uses
// at most one of the ring's two ports. Ring contents read as zero after reset
// without a clearing pass: a write high-water mark marks entries never written,
// so the block is ready the cycle after reset drops.
module ring_buffered_rate_converter #(
   parameter int RING_DEPTH = rbrc_pkg::RING_DEPTH_DEF,
   parameter int FRAME_LEN  = rbrc_pkg::FRAME_LEN_DEF,
   parameter int OUT_RATE   = rbrc_pkg::OUT_RATE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  rbrc_pkg::req_type                 req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output rbrc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [rbrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rbrc_pkg::*;

   localparam int IW = $clog2(RING_DEPTH);

   logic                q_full;
   logic                ring_wr_en, ring_rd_en;
   logic [IW-1:0]       ring_wr_addr, ring_rd_addr;
   logic [STEREO_W-1:0] ring_wr_data, ring_rd_data;
   tick_type            tick;

   assign req_full = q_full;

   rbrc_front #(
      .RING_DEPTH (RING_DEPTH),
      .FRAME_LEN  (FRAME_LEN),
      .OUT_RATE   (OUT_RATE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .q_full       (q_full),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .ring_rd_en   (ring_rd_en),
      .ring_rd_addr (ring_rd_addr),
      .tick         (tick)
   );

   rbrc_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   rbrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .rd_data   (ring_rd_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .q_full    (q_full)
   );

   // The ring is never asked to write and read in one cycle
   a_ring_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ring_wr_en && ring_rd_en))
      else $error("ring written and read in the same cycle");

   // A ring read only happens for a tick that fetches
   a_read_is_fetch: assert property (@(posedge clock) disable iff (reset)
      ring_rd_en |-> (tick.valid && tick.fetch))
      else $error("ring read without a fetching tick");

   // A taken tick is waiting on rsp once it has passed the hold stage into the result queue
   a_tick_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      tick.valid |-> ##2 !rsp_empty)
      else $error("tick beat did not reach the result queue");

endmodule
